### hw/rtl/lapet_pkg.sv
`default_nettype none

package lapet_pkg;

    // Gray values: 306R + 601G + 117B, full white at 255 * 1024
    localparam int GRAY_W = 18;
    localparam int LAP_W  = 22;

    typedef logic [GRAY_W-1:0]       gray_t;
    typedef logic signed [LAP_W-1:0] lap_t;

    localparam gray_t COEF_R      = gray_t'(306);
    localparam gray_t COEF_G      = gray_t'(601);
    localparam gray_t COEF_B      = gray_t'(117);
    localparam gray_t WHITE_LEVEL = gray_t'(261120);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_GEO_W  = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    localparam logic [CFG_GEO_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [CFG_GEO_W-1:0]  HEIGHT_RESET = 12'd480;
    localparam logic [CFG_DATA_W-1:0] THRESH_RESET = 18'd26112;

    // Request commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Neighbor selection and bookkeeping for one request in flight
    typedef struct packed {
        logic has_res;    // request yields a result
        logic is_pix;     // request writes a gray value
        logic up_self;    // top row: up neighbor is the center
        logic left_self;  // first column
        logic right_self; // last column
        logic down_self;  // last row (flush): down neighbor is the center
        logic last;       // final result of the frame
    } sel_t;

    // Geometry register to effective size: zero reads as one, saturate at max
    function automatic int unsigned geo_eff(input logic [CFG_GEO_W-1:0] v,
                                            input int unsigned maxv);
        int unsigned r;
        r = int'(v);
        if (r < 1) r = 1;
        if (r > maxv) r = maxv;
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lapet_line_mem.sv
`default_nettype none

module lapet_line_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire lapet_pkg::gray_t         wdata,
    input  wire logic                     re,
    input  wire logic [AW-1:0]            raddr0,
    input  wire logic [AW-1:0]            raddr1,
    output lapet_pkg::gray_t              rdata0,
    output lapet_pkg::gray_t              rdata1
);
    import lapet_pkg::*;

    gray_t mem [DEPTH];

    // One write, two registered reads; a read of the entry being written
    // returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lapet_ctrl.sv
`default_nettype none

module lapet_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int AW         = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [lapet_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lapet_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                command,
    input  wire logic [7:0]                          red,
    input  wire logic [7:0]                          green,
    input  wire logic [7:0]                          blue,
    input  wire logic                                s2_ready,
    output logic                                     s1_valid,
    output logic                                     s1_move,
    output lapet_pkg::sel_t                          s1_sel,
    output lapet_pkg::gray_t                         s1_gray,
    output logic [AW-1:0]                            s1_waddr,
    output logic [AW-1:0]                            s1_addr_c,
    output logic [AW-1:0]                            s1_addr_r,
    output logic [AW-1:0]                            s1_addr_u,
    output logic [AW-1:0]                            s1_addr_l,
    output logic [lapet_pkg::CFG_DATA_W-1:0]         edge_threshold,
    output logic                                     frame_done
);
    import lapet_pkg::*;

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = 2 * MAX_WIDTH;
    localparam logic [AW:0]   DEPTH_V   = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

    // Configuration
    logic [XW-1:0]         width_m1_reg, width_m1_next;
    logic [YW-1:0]         height_m1_reg, height_m1_next;
    logic [CFG_DATA_W-1:0] thr_reg, thr_next;

    // Input position (next pixel) and result position (next result)
    logic [XW-1:0] in_x_reg, in_x_next;
    logic [YW-1:0] in_y_reg, in_y_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic          in_done_reg, in_done_next;
    logic [XW-1:0] q_x_reg, q_x_next;
    logic [YW-1:0] q_y_reg, q_y_next;
    logic [AW-1:0] q_addr_reg, q_addr_next;

    // Stage 1
    logic          s1_valid_reg;
    sel_t          s1_sel_reg;
    gray_t         s1_gray_reg;
    logic [AW-1:0] s1_waddr_reg, s1_addr_c_reg, s1_addr_r_reg;
    logic [AW-1:0] s1_addr_u_reg, s1_addr_l_reg;

    logic          s1_ready, accept, is_flush, restart, has_res;
    logic [XW-1:0] qx;
    logic [YW-1:0] qy;
    logic [AW-1:0] qa, addr_r, addr_l, addr_u;
    logic [AW:0]   qa_ext, w_ext;
    sel_t          sel;
    gray_t         gray;

    // Handshake
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign accept   = in_valid && s1_ready;
    assign s1_move  = s1_valid_reg && s2_ready;

    // Gray conversion
    assign gray = gray_t'(red) * COEF_R + gray_t'(green) * COEF_G + gray_t'(blue) * COEF_B;

    // Decode of the request against the frame position
    assign is_flush = (command == CMD_FLUSH);
    assign restart  = !is_flush && in_done_reg;
    assign qx       = restart ? '0 : q_x_reg;
    assign qy       = restart ? '0 : q_y_reg;
    assign qa       = restart ? '0 : q_addr_reg;
    assign has_res  = is_flush ? in_done_reg : (in_y_reg != '0);

    always_comb
    begin
        sel            = '0;
        sel.has_res    = has_res;
        sel.is_pix     = !is_flush;
        sel.up_self    = (qy == '0);
        sel.left_self  = (qx == '0);
        sel.right_self = (qx == width_m1_reg);
        sel.down_self  = is_flush;
        sel.last       = (qx == width_m1_reg) && (qy == height_m1_reg);
    end

    // Neighbor addresses, modulo the store depth
    assign qa_ext = {1'b0, qa};
    assign w_ext  = (AW+1)'(width_m1_reg) + (AW+1)'(1);
    assign addr_r = (qa == ADDR_LAST) ? '0 : qa + AW'(1);
    assign addr_l = (qa == '0) ? ADDR_LAST : qa - AW'(1);

    always_comb
    begin
        logic [AW:0] up;
        if (qa_ext >= w_ext)
        begin
            up = qa_ext - w_ext;
        end
        else
        begin
            up = qa_ext + DEPTH_V - w_ext;
        end
        addr_u = up[AW-1:0];
    end

    // Next state of configuration and frame counters
    always_comb
    begin
        logic clear_frame;
        clear_frame    = 1'b0;
        width_m1_next  = width_m1_reg;
        height_m1_next = height_m1_reg;
        thr_next       = thr_reg;
        in_x_next      = in_x_reg;
        in_y_next      = in_y_reg;
        wr_addr_next   = wr_addr_reg;
        in_done_next   = in_done_reg;
        q_x_next       = q_x_reg;
        q_y_next       = q_y_reg;
        q_addr_next    = q_addr_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    width_m1_next = XW'(geo_eff(cfg_data[CFG_GEO_W-1:0], MAX_WIDTH) - 1);
                    clear_frame   = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_m1_next = YW'(geo_eff(cfg_data[CFG_GEO_W-1:0], MAX_HEIGHT) - 1);
                    clear_frame    = 1'b1;
                end
                REG_EDGE_THRESHOLD:
                begin
                    thr_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            // A pixel after a finished frame drops what is pending
            q_x_next    = qx;
            q_y_next    = qy;
            q_addr_next = qa;
            if (restart)
            begin
                in_done_next = 1'b0;
            end

            if (has_res)
            begin
                if (sel.last)
                begin
                    clear_frame = 1'b1;
                end
                else
                begin
                    q_x_next    = (qx == width_m1_reg) ? '0 : qx + XW'(1);
                    q_y_next    = (qx == width_m1_reg) ? qy + YW'(1) : qy;
                    q_addr_next = addr_r;
                end
            end

            if (!is_flush)
            begin
                if (in_x_reg == width_m1_reg)
                begin
                    in_x_next = '0;
                    if (in_y_reg == height_m1_reg)
                    begin
                        in_y_next    = '0;
                        in_done_next = 1'b1;
                    end
                    else
                    begin
                        in_y_next = in_y_reg + YW'(1);
                    end
                end
                else
                begin
                    in_x_next = in_x_reg + XW'(1);
                end
                if (in_x_reg == width_m1_reg && in_y_reg == height_m1_reg)
                begin
                    wr_addr_next = '0;
                end
                else
                begin
                    wr_addr_next = (wr_addr_reg == ADDR_LAST) ? '0 : wr_addr_reg + AW'(1);
                end
            end
        end

        if (clear_frame)
        begin
            in_x_next    = '0;
            in_y_next    = '0;
            wr_addr_next = '0;
            in_done_next = 1'b0;
            q_x_next     = '0;
            q_y_next     = '0;
            q_addr_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_m1_reg  <= XW'(geo_eff(WIDTH_RESET, MAX_WIDTH) - 1);
            height_m1_reg <= YW'(geo_eff(HEIGHT_RESET, MAX_HEIGHT) - 1);
            thr_reg       <= THRESH_RESET;
            in_x_reg      <= '0;
            in_y_reg      <= '0;
            wr_addr_reg   <= '0;
            in_done_reg   <= 1'b0;
            q_x_reg       <= '0;
            q_y_reg       <= '0;
            q_addr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            width_m1_reg  <= width_m1_next;
            height_m1_reg <= height_m1_next;
            thr_reg       <= thr_next;
            in_x_reg      <= in_x_next;
            in_y_reg      <= in_y_next;
            wr_addr_reg   <= wr_addr_next;
            in_done_reg   <= in_done_next;
            q_x_reg       <= q_x_next;
            q_y_reg       <= q_y_next;
            q_addr_reg    <= q_addr_next;
            if (s1_ready)
            begin
                s1_valid_reg <= accept && (!is_flush || has_res);
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sel_reg    <= sel;
            s1_gray_reg   <= gray;
            s1_waddr_reg  <= wr_addr_reg;
            s1_addr_c_reg <= qa;
            s1_addr_r_reg <= addr_r;
            s1_addr_u_reg <= addr_u;
            s1_addr_l_reg <= addr_l;
        end
    end

    assign s1_valid       = s1_valid_reg;
    assign s1_sel         = s1_sel_reg;
    assign s1_gray        = s1_gray_reg;
    assign s1_waddr       = s1_waddr_reg;
    assign s1_addr_c      = s1_addr_c_reg;
    assign s1_addr_r      = s1_addr_r_reg;
    assign s1_addr_u      = s1_addr_u_reg;
    assign s1_addr_l      = s1_addr_l_reg;
    assign edge_threshold = thr_reg;
    assign frame_done     = in_done_reg;

endmodule

`default_nettype wire

### hw/rtl/lapet_filter.sv
`default_nettype none

module lapet_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s1_move,
    input  wire lapet_pkg::sel_t                   s1_sel,
    input  wire lapet_pkg::gray_t                  s1_gray,
    input  wire lapet_pkg::gray_t                  rd_c,
    input  wire lapet_pkg::gray_t                  rd_r,
    input  wire lapet_pkg::gray_t                  rd_u,
    input  wire lapet_pkg::gray_t                  rd_l,
    input  wire logic [lapet_pkg::CFG_DATA_W-1:0]  edge_threshold,
    output logic                                   s2_ready,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   edge_res,
    output logic                                   last_in_frame
);
    import lapet_pkg::*;

    logic            s2_valid_reg;
    sel_t            s2_sel_reg;
    gray_t           s2_gray_reg;
    logic            s3_valid_reg;
    lap_t            s3_a_reg;
    logic [GRAY_W:0] s3_b_reg;
    logic            s3_last_reg;
    logic            out_valid_reg;
    logic            edge_res_reg;
    logic            last_reg;

    logic            out_free, s3_ready;
    gray_t           uv, dv, lv, rv, clamped;
    lap_t            a_sum, lap;
    logic [GRAY_W:0] b_sum;

    // Ready chain
    assign out_free = !out_valid_reg || !out_stall;
    assign s3_ready = !s3_valid_reg || out_free;
    assign s2_ready = !s2_valid_reg || s3_ready;

    // Stage 2: neighbor selection at the frame edges, partial sums
    assign uv    = s2_sel_reg.up_self    ? rd_c : rd_u;
    assign dv    = s2_sel_reg.down_self  ? rd_c : s2_gray_reg;
    assign lv    = s2_sel_reg.left_self  ? rd_c : rd_l;
    assign rv    = s2_sel_reg.right_self ? rd_c : rd_r;
    assign a_sum = lap_t'({rd_c, 2'b00}) - lap_t'(uv) - lap_t'(dv);
    assign b_sum = {1'b0, lv} + {1'b0, rv};

    // Stage 3: final difference, clamp to 0..white, threshold
    assign lap = s3_a_reg - lap_t'(s3_b_reg);

    always_comb
    begin
        if (lap[LAP_W-1])
        begin
            clamped = '0;
        end
        else if (lap > lap_t'(WHITE_LEVEL))
        begin
            clamped = WHITE_LEVEL;
        end
        else
        begin
            clamped = lap[GRAY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= s1_move && s1_sel.has_res;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_sel_reg  <= s1_sel;
            s2_gray_reg <= s1_gray;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_a_reg    <= a_sum;
            s3_b_reg    <= b_sum;
            s3_last_reg <= s2_sel_reg.last;
        end
        if (out_free && s3_valid_reg)
        begin
            edge_res_reg <= (clamped > edge_threshold);
            last_reg     <= s3_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign edge_res      = edge_res_reg;
    assign last_in_frame = last_reg;

endmodule

`default_nettype wire

### hw/rtl/laplacian_edge_threshold_unit.sv
// The request that causes a result (pixel p + width, or a flush of the last
// row) passes stages 1, 2 and 3 and the output register to out_valid.
// Throughput: one request per cycle while not stalled; each of the two line
// store copies takes one write and two reads per cycle, which sets that rate.
// Reset: control, counters and configuration return to their defaults at once;
// the line store is not cleared and needs no clearing pass.
`default_nettype none

module laplacian_edge_threshold_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lapet_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lapet_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              command,
    input  wire logic [7:0]                        red,
    input  wire logic [7:0]                        green,
    input  wire logic [7:0]                        blue,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   edge_res,
    output logic                                   last_in_frame
);
    import lapet_pkg::*;

    localparam int DEPTH = 2 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic                  s1_valid, s1_move, s2_ready, frame_done;
    sel_t                  s1_sel;
    gray_t                 s1_gray, rd_c, rd_r, rd_u, rd_l;
    logic [AW-1:0]         s1_waddr, s1_addr_c, s1_addr_r, s1_addr_u, s1_addr_l;
    logic [CFG_DATA_W-1:0] edge_threshold;
    logic                  mem_we;

    // Frame counters, configuration, address generation
    lapet_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .s2_ready       (s2_ready),
        .s1_valid       (s1_valid),
        .s1_move        (s1_move),
        .s1_sel         (s1_sel),
        .s1_gray        (s1_gray),
        .s1_waddr       (s1_waddr),
        .s1_addr_c      (s1_addr_c),
        .s1_addr_r      (s1_addr_r),
        .s1_addr_u      (s1_addr_u),
        .s1_addr_l      (s1_addr_l),
        .edge_threshold (edge_threshold),
        .frame_done     (frame_done)
    );

    assign mem_we = s1_move && s1_sel.is_pix;

    // Line store copy for center and right neighbors
    lapet_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem_cr (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (s1_waddr),
        .wdata  (s1_gray),
        .re     (s1_move),
        .raddr0 (s1_addr_c),
        .raddr1 (s1_addr_r),
        .rdata0 (rd_c),
        .rdata1 (rd_r)
    );

    // Line store copy for up and left neighbors
    lapet_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem_ul (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (s1_waddr),
        .wdata  (s1_gray),
        .re     (s1_move),
        .raddr0 (s1_addr_u),
        .raddr1 (s1_addr_l),
        .rdata0 (rd_u),
        .rdata1 (rd_l)
    );

    // Laplacian, clamp, threshold, output register
    lapet_filter u_filter (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_move        (s1_move),
        .s1_sel         (s1_sel),
        .s1_gray        (s1_gray),
        .rd_c           (rd_c),
        .rd_r           (rd_r),
        .rd_u           (rd_u),
        .rd_l           (rd_l),
        .edge_threshold (edge_threshold),
        .s2_ready       (s2_ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .edge_res       (edge_res),
        .last_in_frame  (last_in_frame)
    );

    // Input stalls only while stage 1 is full and cannot move on
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid && !s2_ready))
        else $error("input stalled with room in stage 1");

    // A flush in flight always carries a result and never writes the store
    a_flush_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s1_sel.down_self) |-> (s1_sel.has_res && !s1_sel.is_pix))
        else $error("flush request in stage 1 with bad selection");

    // A geometry write abandons the frame
    a_geo_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT))
        |=> !frame_done)
        else $error("frame still complete after geometry write");

endmodule

`default_nettype wire
